@@ hdl/pqi_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pqi_pkg: shared types and constants for the piecewise quadratic interpolator
// Holds field widths, the sequencer state types and the request and response
// structs of the shared multiply-divide unit.
// ----------------------------------------------------------------------------
package pqi_pkg;

	localparam int unsigned MAX_POINTS_DEF = 64;
	localparam int unsigned DATA_W         = 32;
	localparam int unsigned SEG_W          = 6;
	localparam int unsigned CNT_W          = 7;
	localparam int unsigned IDX_W          = 6;
	localparam int unsigned QUOT_W         = 42;

	// Request type codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	// Main sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_FETCH,
		ST_CHECK,
		ST_OP_START,
		ST_OP_WAIT,
		ST_OUT
	} pqi_state_t;

	// Multiply-divide unit phases
	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV,
		MD_DONE
	} pqi_md_state_t;

	typedef struct packed {
		logic               start;
		logic signed [32:0] a;
		logic signed [32:0] b;
		logic signed [32:0] d;
	} pqi_md_req_t;

	typedef struct packed {
		logic                      done;
		logic signed [QUOT_W-1:0] q;
	} pqi_md_rsp_t;

	// Sign-extend a Q16.16 word to 33 bits
	function automatic logic signed [32:0] sx33(input logic [31:0] x);
		return $signed({x[31], x});
	endfunction

endpackage : pqi_pkg
`default_nettype wire

@@ hdl/pqi_muldiv.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pqi_muldiv: iterative a*b/d unit
// Shift-add multiply of the magnitudes (33 steps), then restoring division
// of the 65-bit product (65 steps). Truncates toward zero and clamps the
// quotient magnitude to 2^40. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module pqi_muldiv (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire pqi_pkg::pqi_md_req_t req,
	output pqi_pkg::pqi_md_rsp_t      rsp
);
	import pqi_pkg::*;

	localparam logic [6:0] MUL_LAST = 7'd32;
	localparam logic [6:0] DIV_LAST = 7'd64;
	localparam logic [64:0] Q_CLAMP = 65'h1_0000_0000_00;

	pqi_md_state_t state_q, state_d;
	logic [6:0]  cnt_q;
	logic [65:0] prod_q;
	logic [32:0] ma_q;
	logic [32:0] md_q;
	logic [32:0] rem_q;
	logic        neg_q;

	logic [32:0] mag_a, mag_b, mag_d;
	logic [33:0] mul_sum;
	logic [33:0] rem_sh;
	logic        q_bit;
	logic [40:0] q_clamped;
	logic [QUOT_W-1:0] q_ext;

	// Operand magnitudes
	assign mag_a = req.a[32] ? (~req.a + 33'd1) : req.a;
	assign mag_b = req.b[32] ? (~req.b + 33'd1) : req.b;
	assign mag_d = req.d[32] ? (~req.d + 33'd1) : req.d;

	// Shared adder for the multiply step, subtractor for the divide step
	assign mul_sum = {1'b0, prod_q[65:33]} + (prod_q[0] ? {1'b0, ma_q} : 34'd0);
	assign rem_sh  = {rem_q, prod_q[64]};
	assign q_bit   = (rem_sh >= {1'b0, md_q});

	// Clamp and sign the quotient
	assign q_clamped = (prod_q[64:0] > Q_CLAMP) ? Q_CLAMP[40:0] : prod_q[40:0];
	assign q_ext     = {1'b0, q_clamped};
	assign rsp.done  = (state_q == MD_DONE);
	assign rsp.q     = neg_q ? $signed(~q_ext + QUOT_W'(1)) : $signed(q_ext);

	// Hold phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == MD_IDLE || state_d != state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 7'd1;
			end
		end
	end

	// Next phase
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			MD_IDLE: if (req.start) state_d = MD_MUL;
			MD_MUL:  if (cnt_q == MUL_LAST) state_d = MD_DIV;
			MD_DIV:  if (cnt_q == DIV_LAST) state_d = MD_DONE;
			MD_DONE: state_d = MD_IDLE;
			default: state_d = MD_IDLE;
		endcase
	end

	// Advance the datapath
	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (req.start) begin
					ma_q   <= mag_a;
					md_q   <= mag_d;
					prod_q <= {33'd0, mag_b};
					neg_q  <= (req.a[32] ^ req.b[32]) ^ req.d[32];
					rem_q  <= '0;
				end
			end
			MD_MUL: begin
				prod_q <= {mul_sum, prod_q[32:1]};
			end
			MD_DIV: begin
				rem_q  <= q_bit ? 33'(rem_sh - {1'b0, md_q}) : rem_sh[32:0];
				prod_q <= {1'b0, prod_q[63:0], q_bit};
			end
			default: begin
			end
		endcase
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done) else $error("done held longer than one cycle");
	a_start_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == MD_IDLE && req.start) |=> (state_q == MD_MUL))
		else $error("start not taken");
	a_mul_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == MD_MUL && cnt_q == MUL_LAST) |=> (state_q == MD_DIV && cnt_q == 7'd0))
		else $error("multiply phase length wrong");

endmodule : pqi_muldiv
`default_nettype wire

@@ hdl/piecewise_quadratic_interpolator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_quadratic_interpolator: quadratic interpolation over a point table
// A load transaction stores a (position, value) point in the point table, which
// has one write port and one registered read port. An evaluate transaction scans
// for the segment start (one table read per point stepped over), reads the three
// points, and runs three nested linear interpolations through one shared
// multiply-divide unit. On a divide fault the interpolations are skipped. The
// block takes no new transaction until the result has been taken.
// ----------------------------------------------------------------------------
module piecewise_quadratic_interpolator #(
	parameter int unsigned MAX_POINTS = pqi_pkg::MAX_POINTS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_wr_en,
	input  wire [pqi_pkg::CNT_W-1:0]     cfg_wr_data,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          req_type,
	input  wire [pqi_pkg::IDX_W-1:0]     point_index,
	input  wire signed [31:0]            point_position,
	input  wire signed [31:0]            point_value,
	input  wire signed [31:0]            query_position,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic signed [31:0]           interpolated_value,
	output logic [pqi_pkg::SEG_W-1:0]    segment_start,
	output logic                         divide_fault
);
	import pqi_pkg::*;

	localparam int unsigned AW = $clog2(MAX_POINTS);
	localparam logic signed [42:0] SAT_MAX = 43'sd2147483647;
	localparam logic signed [42:0] SAT_MIN = -43'sd2147483648;

	pqi_state_t state_q, state_d;
	logic [CNT_W-1:0] point_count_q;

	logic [31:0] pos_mem [MAX_POINTS];
	logic [31:0] val_mem [MAX_POINTS];
	logic [31:0] rd_pos_q, rd_val_q;
	logic [AW-1:0] rd_addr;

	logic [AW-1:0] i_q, lim_q;
	logic [1:0]    k_q, op_q;
	logic [31:0]   t_q, t0_q, t1_q, t2_q, v0_q, v1_q, v2_q, va_q, vb_q, res_q;
	logic          fault_q;

	logic          in_acc;
	logic [31:0]   idx32, n32;
	logic          eq_fault;
	pqi_md_req_t   md_req;
	pqi_md_rsp_t   md_rsp;
	logic [31:0]   base;
	logic signed [42:0] sum;
	logic [31:0]   sat_val;
	logic [31:0]   i32;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign in_acc    = in_valid && !in_stall;
	assign idx32     = 32'(point_index);

	// Clamp the point count to the table
	always_comb begin
		n32 = 32'(point_count_q);
		if (n32 < 32'd3) n32 = 32'd3;
		if (n32 > MAX_POINTS) n32 = MAX_POINTS;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CNT_W'(3);
		end else if (cfg_wr_en) begin
			point_count_q <= cfg_wr_data;
		end
	end

	// Point table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (in_acc && req_type == REQ_LOAD && idx32 < MAX_POINTS) begin
			pos_mem[idx32[AW-1:0]] <= point_position;
			val_mem[idx32[AW-1:0]] <= point_value;
		end
		rd_pos_q <= pos_mem[rd_addr];
		rd_val_q <= val_mem[rd_addr];
	end

	// Read address
	always_comb begin
		case (state_q)
			ST_SCAN_RD: rd_addr = i_q + AW'(1);
			ST_FETCH:   rd_addr = (k_q == 2'd3) ? i_q : i_q + AW'(k_q);
			default:    rd_addr = i_q;
		endcase
	end

	assign eq_fault = (t1_q == t0_q) || (t2_q == t1_q) || (t2_q == t0_q);

	// Operand select for the shared unit
	always_comb begin
		md_req.start = (state_q == ST_OP_START);
		case (op_q)
			2'd0: begin
				md_req.a = sx33(v1_q) - sx33(v0_q);
				md_req.b = sx33(t_q) - sx33(t0_q);
				md_req.d = sx33(t1_q) - sx33(t0_q);
				base     = v0_q;
			end
			2'd1: begin
				md_req.a = sx33(v2_q) - sx33(v1_q);
				md_req.b = sx33(t_q) - sx33(t1_q);
				md_req.d = sx33(t2_q) - sx33(t1_q);
				base     = v1_q;
			end
			default: begin
				md_req.a = sx33(vb_q) - sx33(va_q);
				md_req.b = sx33(t_q) - sx33(t0_q);
				md_req.d = sx33(t2_q) - sx33(t0_q);
				base     = va_q;
			end
		endcase
	end

	pqi_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	// Add quotient to base and saturate
	assign sum = $signed({{11{base[31]}}, base}) + $signed({md_rsp.q[QUOT_W-1], md_rsp.q});
	always_comb begin
		if (sum > SAT_MAX) begin
			sat_val = 32'h7FFF_FFFF;
		end else if (sum < SAT_MIN) begin
			sat_val = 32'h8000_0000;
		end else begin
			sat_val = sum[31:0];
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_acc && req_type == REQ_EVAL) state_d = ST_SCAN_RD;
			ST_SCAN_RD:  state_d = (i_q >= lim_q) ? ST_FETCH : ST_SCAN_CMP;
			ST_SCAN_CMP: state_d = ($signed(t_q) > $signed(rd_pos_q)) ? ST_SCAN_RD : ST_FETCH;
			ST_FETCH:    if (k_q == 2'd3) state_d = ST_CHECK;
			ST_CHECK:    state_d = eq_fault ? ST_OUT : ST_OP_START;
			ST_OP_START: state_d = ST_OP_WAIT;
			ST_OP_WAIT:  if (md_rsp.done) state_d = (op_q == 2'd2) ? ST_OUT : ST_OP_START;
			ST_OUT:      if (!out_stall) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				i_q   <= '0;
				k_q   <= '0;
				op_q  <= '0;
				t_q   <= query_position;
				lim_q <= AW'(n32 - 32'd3);
			end
			ST_SCAN_CMP: begin
				if ($signed(t_q) > $signed(rd_pos_q)) i_q <= i_q + AW'(1);
			end
			ST_FETCH: begin
				k_q <= k_q + 2'd1;
				case (k_q)
					2'd1: begin t0_q <= rd_pos_q; v0_q <= rd_val_q; end
					2'd2: begin t1_q <= rd_pos_q; v1_q <= rd_val_q; end
					2'd3: begin t2_q <= rd_pos_q; v2_q <= rd_val_q; end
					default: begin end
				endcase
			end
			ST_CHECK: begin
				fault_q <= eq_fault;
				res_q   <= '0;
			end
			ST_OP_WAIT: begin
				if (md_rsp.done) begin
					op_q <= op_q + 2'd1;
					case (op_q)
						2'd0:    va_q  <= sat_val;
						2'd1:    vb_q  <= sat_val;
						default: res_q <= sat_val;
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// Drive result
	assign i32                = 32'(i_q);
	assign interpolated_value = res_q;
	assign segment_start      = i32[SEG_W-1:0];
	assign divide_fault       = fault_q;

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && divide_fault) |-> (interpolated_value == 32'd0))
		else $error("fault result not zero");
	a_seg_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_SCAN_RD && state_q != ST_SCAN_CMP) |-> (i_q <= lim_q))
		else $error("segment start beyond last segment");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !out_valid)
		else $error("result repeated");

endmodule : piecewise_quadratic_interpolator
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for the piecewise quadratic interpolator
// Loads point tables, runs queries under several idle and stall patterns and
// point counts, and checks every response against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb;
	import pqi_pkg::*;

	// Predictor of the interpolator and store of expected responses
	class interp_scoreboard;
		logic [31:0] pos_tab [64];
		logic [31:0] val_tab [64];
		logic [6:0]  count_reg;
		logic [31:0] exp_value [$];
		logic [5:0]  exp_seg [$];
		logic        exp_fault [$];
		int          errors;

		function new();
			count_reg = 7'd3;
			errors = 0;
		endfunction

		function automatic longint mul_div(longint a, longint b, longint d);
			longint ma, mb, md, q;
			longint unsigned uq;
			bit neg;
			ma = a < 0 ? -a : a;
			mb = b < 0 ? -b : b;
			md = d < 0 ? -d : d;
			uq = (unsigned'(ma) * unsigned'(mb)) / unsigned'(md);
			if (uq > (64'd1 << 40)) uq = 64'd1 << 40;
			q = longint'(uq);
			neg = ((a < 0) != (b < 0)) != (d < 0);
			if (ma == 0 || mb == 0) return 0;
			return neg ? -q : q;
		endfunction

		function automatic longint lerp_sat(longint base, longint other, longint t,
			longint ta, longint tb2);
			longint s;
			s = base + mul_div(other - base, t - ta, tb2 - ta);
			if (s > 64'sd2147483647) s = 64'sd2147483647;
			if (s < -64'sd2147483648) s = -64'sd2147483648;
			return s;
		endfunction

		// Note an accepted input transaction
		function void note_input(logic rt, logic [5:0] idx, logic [31:0] pp,
			logic [31:0] pv, logic [31:0] qp);
			int n, i;
			longint t, t0, t1, t2, v0, v1, v2, va, vb, r;
			logic f;
			if (rt == REQ_LOAD) begin
				pos_tab[idx] = pp;
				val_tab[idx] = pv;
				return;
			end
			n = count_reg;
			if (n < 3) n = 3;
			if (n > 64) n = 64;
			t = $signed(qp);
			i = 0;
			while (i < n - 3 && t > longint'($signed(pos_tab[i + 1]))) i++;
			t0 = $signed(pos_tab[i]);
			t1 = $signed(pos_tab[i + 1]);
			t2 = $signed(pos_tab[i + 2]);
			v0 = $signed(val_tab[i]);
			v1 = $signed(val_tab[i + 1]);
			v2 = $signed(val_tab[i + 2]);
			r = 0;
			f = 1'b0;
			if (t1 == t0 || t2 == t1 || t2 == t0) f = 1'b1;
			else begin
				va = lerp_sat(v0, v1, t, t0, t1);
				vb = lerp_sat(v1, v2, t, t1, t2);
				r = lerp_sat(va, vb, t, t0, t2);
			end
			exp_value.push_back(r[31:0]);
			exp_seg.push_back(i[5:0]);
			exp_fault.push_back(f);
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		// Check one response against the oldest expectation
		task check_result(logic [31:0] v, logic [5:0] s, logic f);
			logic [31:0] ev;
			logic [5:0] es;
			logic ef;
			if (exp_value.size() == 0) begin
				report("response with nothing expected");
				return;
			end
			ev = exp_value.pop_front();
			es = exp_seg.pop_front();
			ef = exp_fault.pop_front();
			if (v !== ev) report($sformatf("value %h expected %h", v, ev));
			if (s !== es) report($sformatf("segment %0d expected %0d", s, es));
			if (f !== ef) report($sformatf("fault %b expected %b", f, ef));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [6:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = 1'b0;
	logic [5:0] point_index = '0;
	logic signed [31:0] point_position = '0;
	logic signed [31:0] point_value = '0;
	logic signed [31:0] query_position = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] interpolated_value;
	logic [5:0] segment_start;
	logic divide_fault;

	interp_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;
	int quiet_cycles = 0;
	logic [31:0] shadow_pos [64];
	logic [6:0] cur_count = 7'd3;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	piecewise_quadratic_interpolator DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .point_index(point_index),
		.point_position(point_position), .point_value(point_value),
		.query_position(query_position),
		.out_valid(out_valid), .out_stall(out_stall),
		.interpolated_value(interpolated_value),
		.segment_start(segment_start), .divide_fault(divide_fault)
	);

	// Sample at the rising edge: score transactions, run the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_input(req_type, point_index, point_position, point_value,
					query_position);
			if (out_valid && !out_stall)
				sb.check_result(interpolated_value, segment_start, divide_fault);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles > 20000) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Receiver: random stall, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_stall <= 1'b1;
			hold_off--;
		end else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Offer one transaction, with random idle beforehand
	task send_item(logic rt, logic [5:0] idx, logic [31:0] pp, logic [31:0] pv,
		logic [31:0] qp);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		point_index <= idx;
		point_position <= pp;
		point_value <= pv;
		query_position <= qp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		if (rt == REQ_LOAD) shadow_pos[idx] = pp;
	endtask

	task drain();
		in_valid <= 1'b0;
		while (sb.exp_value.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task write_count(logic [6:0] c);
		in_valid <= 1'b0;
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= c;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.count_reg = c;
		cur_count = c;
	endtask

	// Load all 64 slots with ascending positions; occasional repeats
	task load_table(bit dup);
		logic [31:0] p;
		p = $urandom_range(3) == 0 ? 32'h8000_0000 + $urandom_range(255)
			: -($urandom_range(65535) << 8);
		for (int k = 0; k < 64; k++) begin
			send_item(REQ_LOAD, k[5:0], p, $urandom(), $urandom());
			if (!(dup && $urandom_range(7) == 0))
				p = p + 1 + ($urandom_range(3) == 0 ? $urandom_range(32'h0100_0000)
					: $urandom_range(32'h0003_0000));
		end
	endtask

	function automatic logic [31:0] pick_query();
		int n;
		n = cur_count < 3 ? 3 : cur_count;
		if (n > 64) n = 64;
		case ($urandom_range(5))
			0: return $urandom();
			1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
			2: return shadow_pos[$urandom_range(n - 1)];
			default: return shadow_pos[$urandom_range(n - 1)] + $urandom_range(32'h0002_0000)
				- 32'h0001_0000;
		endcase
	endfunction

	task random_phase(int items);
		for (int k = 0; k < items; k++) begin
			if ($urandom_range(9) == 0)
				send_item(REQ_LOAD, 6'($urandom()), shadow_pos[0], $urandom(), $urandom());
			else
				send_item(REQ_EVAL, 6'($urandom()), $urandom(), $urandom(), pick_query());
		end
	endtask

	initial begin
		logic [6:0] counts [6];
		counts = '{7'd3, 7'd64, 7'd0, 7'd127, 7'd5, 7'd20};
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extremes, repeated positions, count extremes
		load_table(1'b0);
		send_item(REQ_LOAD, 6'd1, shadow_pos[0], 32'h7fff_ffff, '0);
		send_item(REQ_EVAL, '0, '0, '0, 32'h8000_0000);
		send_item(REQ_EVAL, '0, '0, '0, 32'h7fff_ffff);
		send_item(REQ_EVAL, '0, '0, '0, 32'h0000_0000);
		drain();
		write_count(7'd64);
		send_item(REQ_LOAD, 6'd63, 32'h7fff_ffff, 32'h8000_0000, '0);
		send_item(REQ_LOAD, 6'd62, 32'h7fff_fffe, 32'h7fff_ffff, '0);
		send_item(REQ_EVAL, 6'h3f, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
		send_item(REQ_EVAL, '0, '0, '0, 32'h8000_0000);
		send_item(REQ_EVAL, '0, '0, '0, shadow_pos[30]);
		send_item(REQ_LOAD, 6'd2, shadow_pos[0], '0, '0);
		write_count(7'd3);
		drain();
		write_count(7'd3);
		send_item(REQ_EVAL, '0, '0, '0, 32'h1234_5678);
		send_item(REQ_EVAL, '0, '0, '0, shadow_pos[0]);
		drain();

		// Long hold-off so the block backs up its input
		hold_off = 3000;
		send_item(REQ_EVAL, '0, '0, '0, 32'h0);
		send_item(REQ_EVAL, '0, '0, '0, 32'h1);
		send_item(REQ_EVAL, '0, '0, '0, 32'h2);
		drain();

		// Random phases across idle patterns and point counts
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 55; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 55; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			write_count(counts[ph % 6]);
			load_table(ph % 3 == 2);
			random_phase(130);
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
